// ----- hdl/dltc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltc_pkg: shared types and constants
// Field widths, register indexes and the words passed between the front,
// the queue and the back of the LBA to CHS translator.
// ----------------------------------------------------------------------------
package dltc_pkg;

  localparam int NUM_DRIVES_DEF      = 2;
  localparam int PARTS_PER_DRIVE_DEF = 5;

  localparam int MINOR_W  = 8;
  localparam int START_W  = 28;
  localparam int COUNT_W  = 8;
  localparam int DRVCNT_W = 2;
  localparam int SPT_W    = 8;
  localparam int HEADS_W  = 5;
  localparam int CYL_W    = 16;
  localparam int SECT_W   = 8;
  localparam int HEAD_W   = 4;
  localparam int CH_W     = CYL_W + HEADS_W;   // cylinders * heads
  localparam int SIZE_W   = CH_W + SPT_W;      // whole-disk size

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STEPS   = 7;             // quotient bits per divider cycle

  typedef enum logic [2:0] {
    REG_DRIVE_COUNT = 3'd0,
    REG_SPT_A       = 3'd1,
    REG_HEADS_A     = 3'd2,
    REG_CYL_A       = 3'd3,
    REG_SPT_B       = 3'd4,
    REG_HEADS_B     = 3'd5,
    REG_CYL_B       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [DRVCNT_W-1:0] drive_count;
    logic [SPT_W-1:0]    spt_a;
    logic [HEADS_W-1:0]  heads_a;
    logic [CYL_W-1:0]    cyl_a;
    logic [SPT_W-1:0]    spt_b;
    logic [HEADS_W-1:0]  heads_b;
    logic [CYL_W-1:0]    cyl_b;
  } cfg_t;

  // classified request, front to back
  typedef struct packed {
    logic                accepted;
    logic                drive;
    logic [START_W-1:0]  start;
    logic [SPT_W-1:0]    spt;
    logic [HEADS_W-1:0]  heads;
    logic [COUNT_W-1:0]  count;
    logic                wr;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               drive;
    logic [SECT_W-1:0]  sector_number;
    logic [HEAD_W-1:0]  head_number;
    logic [CYL_W-1:0]   cylinder_number;
    logic [COUNT_W-1:0] count_out;
    logic               write_out;
  } rsp_t;

endpackage

// ----- hdl/dltc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltc_req_if: disk request channel
// valid/ready channel carrying one disk request word.
// ----------------------------------------------------------------------------
interface dltc_req_if;
  import dltc_pkg::*;

  logic               valid;
  logic               ready;
  logic [MINOR_W-1:0] minor_device;
  logic [START_W-1:0] start_lba;
  logic [COUNT_W-1:0] sector_count;
  logic               is_write;

  modport source (output valid, minor_device, start_lba, sector_count, is_write,
                  input ready);
  modport sink   (input valid, minor_device, start_lba, sector_count, is_write,
                  output ready);
endinterface

// ----- hdl/dltc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltc_rsp_if: translation result channel
// valid/ready channel carrying one CHS result word.
// ----------------------------------------------------------------------------
interface dltc_rsp_if;
  import dltc_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic               drive;
  logic [SECT_W-1:0]  sector_number;
  logic [HEAD_W-1:0]  head_number;
  logic [CYL_W-1:0]   cylinder_number;
  logic [COUNT_W-1:0] count_out;
  logic               write_out;

  modport source (output valid, accepted, drive, sector_number, head_number,
                  cylinder_number, count_out, write_out, input ready);
  modport sink   (input valid, accepted, drive, sector_number, head_number,
                  cylinder_number, count_out, write_out, output ready);
endinterface

// ----- hdl/dltc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltc_front: request classifier
// Decodes the minor number, selects the drive geometry and checks the
// request against the whole-disk size. One register stage, then the
// size multiply and range compare feed the queue.
// ----------------------------------------------------------------------------
module dltc_front #(
  parameter int NUM_DRIVES      = dltc_pkg::NUM_DRIVES_DEF,
  parameter int PARTS_PER_DRIVE = dltc_pkg::PARTS_PER_DRIVE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dltc_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dltc_pkg::MINOR_W-1:0] minor_device,
  input  logic [dltc_pkg::START_W-1:0] start_lba,
  input  logic [dltc_pkg::COUNT_W-1:0] sector_count,
  input  logic                         is_write,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dltc_pkg::req_t               out_word
);
  import dltc_pkg::*;

  logic [DRVCNT_W-1:0] drv_count_eff;
  logic [3:0]          minor_limit;
  logic                in_range;
  logic                drv_hi;
  logic                whole_disk;
  logic [SPT_W-1:0]    spt_sel;
  logic [HEADS_W-1:0]  heads_sel;
  logic [CYL_W-1:0]    cyl_sel;
  logic                load;

  logic                s1_valid;
  logic                s1_part_ok;
  logic                s1_drive;
  logic [CH_W-1:0]     s1_cyl_heads;
  logic [SPT_W-1:0]    s1_spt;
  logic [HEADS_W-1:0]  s1_heads;
  logic [START_W-1:0]  s1_start;
  logic [COUNT_W-1:0]  s1_count;
  logic                s1_wr;

  logic [SIZE_W-1:0]   disk_size;
  logic [SIZE_W-1:0]   need;

  always_comb begin
    drv_count_eff = (cfg.drive_count > DRVCNT_W'(NUM_DRIVES)) ?
                    DRVCNT_W'(NUM_DRIVES) : cfg.drive_count;
    minor_limit   = 4'(drv_count_eff) * 4'(PARTS_PER_DRIVE);
    in_range      = minor_device < MINOR_W'(minor_limit);
    // in range implies minor below two drives' worth of partitions
    drv_hi        = (NUM_DRIVES > 1) && (minor_device >= MINOR_W'(PARTS_PER_DRIVE));
    whole_disk    = (minor_device == '0) ||
                    (minor_device == MINOR_W'(PARTS_PER_DRIVE));
    spt_sel       = drv_hi ? cfg.spt_b   : cfg.spt_a;
    heads_sel     = drv_hi ? cfg.heads_b : cfg.heads_a;
    cyl_sel       = drv_hi ? cfg.cyl_b   : cfg.cyl_a;
  end

  assign in_ready = !s1_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_part_ok   <= in_range && whole_disk;
      s1_drive     <= drv_hi;
      s1_cyl_heads <= CH_W'(cyl_sel) * CH_W'(heads_sel);
      s1_spt       <= spt_sel;
      s1_heads     <= heads_sel;
      s1_start     <= start_lba;
      s1_count     <= sector_count;
      s1_wr        <= is_write;
    end
  end

  always_comb begin
    disk_size = SIZE_W'(s1_cyl_heads) * SIZE_W'(s1_spt);
    need      = SIZE_W'(s1_start) + SIZE_W'(2);
    out_word.accepted = s1_part_ok && (need <= disk_size);
    out_word.drive    = s1_drive;
    out_word.start    = s1_start;
    out_word.spt      = s1_spt;
    out_word.heads    = s1_heads;
    out_word.count    = s1_count;
    out_word.wr       = s1_wr;
  end

  assign out_valid = s1_valid;

endmodule

// ----- hdl/dltc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltc_queue: request queue
// Small flip-flop FIFO between the classifier and the translator.
// ----------------------------------------------------------------------------
module dltc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dltc_pkg::req_t in_word,
  output logic           out_valid,
  input  logic           out_ready,
  output dltc_pkg::req_t out_word
);
  import dltc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  req_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic          push;
  logic          pop;

  assign in_ready  = fill != (AW+1)'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop)  rd_ptr <= rd_ptr + AW'(1);
      if (push && !pop)      fill <= fill + (AW+1)'(1);
      else if (pop && !push) fill <= fill - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_word;
  end

endmodule

// ----- hdl/dltc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltc_div: iterative unsigned divider
// Restoring division, DIV_STEPS quotient bits per cycle; the loading cycle
// already does the first group. A tag rides along with the operands.
// ----------------------------------------------------------------------------
module dltc_div #(
  parameter int N     = 28,
  parameter int D     = 8,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [N-1:0]     in_dividend,
  input  logic [D-1:0]     in_divisor,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [N-1:0]     out_quot,
  output logic [D-1:0]     out_rem,
  output logic [TAG_W-1:0] out_tag
);
  import dltc_pkg::*;

  localparam int S    = DIV_STEPS;
  localparam int ITER = (N + S - 1) / S;      // two or more
  localparam int NP   = ITER * S;
  localparam int CW   = $clog2(ITER);

  function automatic logic [D+S-1:0] div_group(input logic [D-1:0] r_in,
                                               input logic [S-1:0] bits,
                                               input logic [D-1:0] dv);
    logic [D-1:0] r;
    logic [D:0]   t;
    logic [S-1:0] qb;
    r  = r_in;
    qb = '0;
    for (int i = S - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, dv}) begin
        r     = D'(t - {1'b0, dv});
        qb[i] = 1'b1;
      end else begin
        r = t[D-1:0];
      end
    end
    return {r, qb};
  endfunction

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [D-1:0]      rem;
  logic [NP-1:0]     quo;
  logic [D-1:0]      dvs;
  logic [TAG_W-1:0]  tag;
  logic              load;

  logic [D-1:0]      src_rem;
  logic [NP-1:0]     src_quo;
  logic [D-1:0]      src_dvs;
  logic [D+S-1:0]    grp;
  logic [D-1:0]      rem_next;
  logic [NP-1:0]     quo_next;

  assign in_ready = !busy && (!out_valid || out_ready);
  assign load     = in_valid && in_ready;

  always_comb begin
    src_rem  = load ? '0 : rem;
    src_quo  = load ? NP'(in_dividend) : quo;
    src_dvs  = load ? in_divisor : dvs;
    grp      = div_group(src_rem, src_quo[NP-1 -: S], src_dvs);
    rem_next = grp[D+S-1:S];
    // dividend bits leave at the top, quotient bits enter at the bottom
    quo_next = {src_quo[NP-S-1:0], grp[S-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (load) begin
        busy <= 1'b1;
        cnt  <= CW'(ITER - 1);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy      <= 1'b0;
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load || busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (load) begin
      dvs <= in_divisor;
      tag <= in_tag;
    end
  end

  assign out_quot = quo[N-1:0];
  assign out_rem  = rem;
  assign out_tag  = tag;

endmodule

// ----- hdl/dltc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltc_back: CHS translator
// Two chained dividers (start / sectors per track, then track / heads)
// and an output register that zeroes rejected results.
// ----------------------------------------------------------------------------
module dltc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dltc_pkg::req_t in_word,
  output logic           out_valid,
  input  logic           out_ready,
  output dltc_pkg::rsp_t out_word
);
  import dltc_pkg::*;

  typedef struct packed {
    logic               accepted;
    logic               drive;
    logic [HEADS_W-1:0] heads;
    logic [COUNT_W-1:0] count;
    logic               wr;
  } tag1_t;

  typedef struct packed {
    logic               accepted;
    logic               drive;
    logic [SECT_W-1:0]  sector;
    logic [COUNT_W-1:0] count;
    logic               wr;
  } tag2_t;

  tag1_t              tag1_in;
  tag1_t              tag1_out;
  tag2_t              tag2_in;
  tag2_t              tag2_out;
  logic               d1_valid;
  logic               d1_ready;
  logic [START_W-1:0] track;
  logic [SPT_W-1:0]   sect_rem;
  logic               d2_valid;
  logic               d2_ready;
  logic [START_W-1:0] cyl_quot;
  logic [HEADS_W-1:0] head_rem;
  logic               take;

  always_comb begin
    tag1_in.accepted = in_word.accepted;
    tag1_in.drive    = in_word.drive;
    tag1_in.heads    = in_word.heads;
    tag1_in.count    = in_word.count;
    tag1_in.wr       = in_word.wr;
  end

  dltc_div #(
    .N     (START_W),
    .D     (SPT_W),
    .TAG_W ($bits(tag1_t))
  ) u_div_track (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_dividend (in_word.start),
    .in_divisor  (in_word.spt),
    .in_tag      (tag1_in),
    .out_valid   (d1_valid),
    .out_ready   (d1_ready),
    .out_quot    (track),
    .out_rem     (sect_rem),
    .out_tag     (tag1_out)
  );

  always_comb begin
    tag2_in.accepted = tag1_out.accepted;
    tag2_in.drive    = tag1_out.drive;
    tag2_in.sector   = SECT_W'(sect_rem + SPT_W'(1));   // sectors count from one
    tag2_in.count    = tag1_out.count;
    tag2_in.wr       = tag1_out.wr;
  end

  dltc_div #(
    .N     (START_W),
    .D     (HEADS_W),
    .TAG_W ($bits(tag2_t))
  ) u_div_cyl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (d1_valid),
    .in_ready    (d1_ready),
    .in_dividend (track),
    .in_divisor  (tag1_out.heads),
    .in_tag      (tag2_in),
    .out_valid   (d2_valid),
    .out_ready   (d2_ready),
    .out_quot    (cyl_quot),
    .out_rem     (head_rem),
    .out_tag     (tag2_out)
  );

  assign d2_ready = !out_valid || out_ready;
  assign take     = d2_valid && d2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d2_ready) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (tag2_out.accepted) begin
        out_word.accepted        <= 1'b1;
        out_word.drive           <= tag2_out.drive;
        out_word.sector_number   <= tag2_out.sector;
        out_word.head_number     <= head_rem[HEAD_W-1:0];
        out_word.cylinder_number <= cyl_quot[CYL_W-1:0];
        out_word.count_out       <= tag2_out.count;
        out_word.write_out       <= tag2_out.wr;
      end else begin
        out_word <= '0;
      end
    end
  end

endmodule

// ----- hdl/disk_request_lba_to_chs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_request_lba_to_chs: disk request LBA to CHS translator
// Checks each request against the drive geometry and turns the start
// sector into drive, 1-based sector, head and cylinder.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    minor_device, start_lba, sector_count,
//                                is_write
//   rsp      out  valid/ready    accepted, drive, sector_number, head_number,
//                                cylinder_number, count_out, write_out
//   apb      in   psel/penable   geometry registers at byte address 4*index
//
// One result word per request. Each of the translator's two dividers works
// 7 quotient bits per cycle over 28 bits and takes no new word until it is
// done with the last. The classifier and a 4-word queue keep taking requests
// while the translator or the rsp side stalls, until the queue is full.
// Synchronous reset clears all control state and sets the geometry
// registers to their reset values.
// ----------------------------------------------------------------------------
module disk_request_lba_to_chs #(
  parameter int NUM_DRIVES      = dltc_pkg::NUM_DRIVES_DEF,
  parameter int PARTS_PER_DRIVE = dltc_pkg::PARTS_PER_DRIVE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  dltc_req_if.sink                    req,
  dltc_rsp_if.source                  rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dltc_pkg::ADDR_W-1:0] paddr,
  input  logic [dltc_pkg::DATA_W-1:0] pwdata,
  output logic [dltc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dltc_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic     q_in_valid;
  logic     q_in_ready;
  req_t     q_in_word;
  logic     q_out_valid;
  logic     q_out_ready;
  req_t     q_out_word;
  rsp_t     rsp_word;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_count <= '0;
      cfg.spt_a       <= SPT_W'(1);
      cfg.heads_a     <= HEADS_W'(1);
      cfg.cyl_a       <= '0;
      cfg.spt_b       <= SPT_W'(1);
      cfg.heads_b     <= HEADS_W'(1);
      cfg.cyl_b       <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DRIVE_COUNT: cfg.drive_count <= pwdata[DRVCNT_W-1:0];
        REG_SPT_A:       cfg.spt_a       <= pwdata[SPT_W-1:0];
        REG_HEADS_A:     cfg.heads_a     <= pwdata[HEADS_W-1:0];
        REG_CYL_A:       cfg.cyl_a       <= pwdata[CYL_W-1:0];
        REG_SPT_B:       cfg.spt_b       <= pwdata[SPT_W-1:0];
        REG_HEADS_B:     cfg.heads_b     <= pwdata[HEADS_W-1:0];
        REG_CYL_B:       cfg.cyl_b       <= pwdata[CYL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DRIVE_COUNT: prdata = DATA_W'(cfg.drive_count);
      REG_SPT_A:       prdata = DATA_W'(cfg.spt_a);
      REG_HEADS_A:     prdata = DATA_W'(cfg.heads_a);
      REG_CYL_A:       prdata = DATA_W'(cfg.cyl_a);
      REG_SPT_B:       prdata = DATA_W'(cfg.spt_b);
      REG_HEADS_B:     prdata = DATA_W'(cfg.heads_b);
      REG_CYL_B:       prdata = DATA_W'(cfg.cyl_b);
      default:         prdata = '0;
    endcase
  end

  dltc_front #(
    .NUM_DRIVES      (NUM_DRIVES),
    .PARTS_PER_DRIVE (PARTS_PER_DRIVE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .minor_device (req.minor_device),
    .start_lba    (req.start_lba),
    .sector_count (req.sector_count),
    .is_write     (req.is_write),
    .out_valid    (q_in_valid),
    .out_ready    (q_in_ready),
    .out_word     (q_in_word)
  );

  dltc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_word   (q_in_word),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_word  (q_out_word)
  );

  dltc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_out_valid),
    .in_ready  (q_out_ready),
    .in_word   (q_out_word),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_word  (rsp_word)
  );

  assign rsp.accepted        = rsp_word.accepted;
  assign rsp.drive           = rsp_word.drive;
  assign rsp.sector_number   = rsp_word.sector_number;
  assign rsp.head_number     = rsp_word.head_number;
  assign rsp.cylinder_number = rsp_word.cylinder_number;
  assign rsp.count_out       = rsp_word.count_out;
  assign rsp.write_out       = rsp_word.write_out;

endmodule
